[src/bnt_pkg.sv]
`timescale 1ns / 1ps
package bnt_pkg;

	// table geometry
	localparam int TABLE_SLOTS = 64;
	localparam int SLOT_W      = 6;
	localparam int CNT_W       = 7;
	localparam int ADDR_W      = 48;
	localparam int GEN_W       = 32;
	localparam int QUEUE_DEPTH = 2;

	// request modes
	localparam logic [2:0] MODE_START    = 3'd0;
	localparam logic [2:0] MODE_ENTRY    = 3'd1;
	localparam logic [2:0] MODE_END      = 3'd2;
	localparam logic [2:0] MODE_DESIRED  = 3'd3;
	localparam logic [2:0] MODE_EVENT    = 3'd4;
	localparam logic [2:0] MODE_DISASSOC = 3'd5;

	typedef enum logic [2:0] {
		ST_INIT  = 3'd0,
		ST_SCAN  = 3'd1,
		ST_AUTH  = 3'd2,
		ST_ASSOC = 3'd3,
		ST_RUN   = 3'd4
	} assoc_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_START,
		OP_ENTRY,
		OP_END,
		OP_DESIRED,
		OP_EVENT,
		OP_DISASSOC
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [ADDR_W-1:0]   bssid;
		logic                present;
		logic                scanning;
		assoc_t              target;
	} op_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WALK,
		B_FINISH,
		B_EMIT
	} b_state_t;

	// control decided by the back end when it takes a request
	typedef struct packed {
		logic              pop;
		logic              start_walk;
		logic              walk_entry;
		logic [ADDR_W-1:0] walk_key;
	} b_ctl_t;

endpackage

[src/bnt_in_if.sv]
`timescale 1ns / 1ps
interface bnt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [47:0] bssid;
	logic        bssid_present;
	logic        scan_in_progress;
	logic [2:0]  new_state;

	modport source (
		output valid, mode, bssid, bssid_present, scan_in_progress, new_state,
		input  ready
	);
	modport sink (
		input  valid, mode, bssid, bssid_present, scan_in_progress, new_state,
		output ready
	);
endinterface

[src/bnt_out_if.sv]
`timescale 1ns / 1ps
interface bnt_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] slot;
	logic       hit;
	logic       accepted;
	logic [2:0] assoc_state;
	logic       bound_valid;
	logic [5:0] bound_slot;
	logic [6:0] visible_count;

	modport source (
		output valid, slot, hit, accepted, assoc_state, bound_valid, bound_slot,
		       visible_count,
		input  ready
	);
	modport sink (
		input  valid, slot, hit, accepted, assoc_state, bound_valid, bound_slot,
		       visible_count,
		output ready
	);
endinterface

[src/bnt_front.sv]
`timescale 1ns / 1ps
module bnt_front
	import bnt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	bnt_in_if.sink   in_ch,
	output op_t      op,
	output logic     op_valid,
	input  logic     op_pop
);

	op_t        queue_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	op_t        cls;

	// decode the mode; bad modes and out of range targets become no-ops
	always_comb begin
		cls.bssid    = in_ch.bssid;
		cls.present  = in_ch.bssid_present;
		cls.scanning = in_ch.scan_in_progress;
		cls.target   = ST_INIT;
		case (in_ch.mode)
			MODE_START:    cls.kind = OP_START;
			MODE_ENTRY:    cls.kind = OP_ENTRY;
			MODE_END:      cls.kind = OP_END;
			MODE_DESIRED:  cls.kind = OP_DESIRED;
			MODE_EVENT: begin
				if (in_ch.new_state <= 3'(ST_RUN)) begin
					cls.kind   = OP_EVENT;
					cls.target = assoc_t'(in_ch.new_state);
				end else begin
					cls.kind = OP_NOP;
				end
			end
			MODE_DISASSOC: cls.kind = OP_DISASSOC;
			default:       cls.kind = OP_NOP;
		endcase
	end

	assign in_ch.ready = (count_q != 2'(QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign op_valid    = (count_q != 2'd0);
	assign op          = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (op_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, op_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/bnt_back.sv]
`timescale 1ns / 1ps
module bnt_back
	import bnt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  op_t      op,
	input  logic     op_valid,
	output logic     op_pop,
	bnt_out_if.source out_ch
);

	b_state_t                state_q, state_nxt;
	b_ctl_t                  ctl;

	logic [TABLE_SLOTS-1:0]  node_valid_q;
	logic [TABLE_SLOTS-1:0]  node_touched_q;
	logic [ADDR_W-1:0]       node_addr_mem [TABLE_SLOTS];
	logic [GEN_W-1:0]        node_gen_mem  [TABLE_SLOTS];

	logic [CNT_W-1:0]        total_q;
	logic [GEN_W-1:0]        scan_gen_q;
	assoc_t                  cur_q;
	logic                    bound_q;
	logic [SLOT_W-1:0]       bidx_q;
	logic [ADDR_W-1:0]       desired_q;

	// walk over the table
	logic [CNT_W-1:0]        cnt_q;
	logic                    walk_entry_q;
	logic [ADDR_W-1:0]       key_q;
	logic                    pend_s1;
	logic [SLOT_W-1:0]       idx_s1;
	logic [ADDR_W-1:0]       rd_addr_s1;
	logic [GEN_W-1:0]        rd_gen_s1;
	logic                    found_q, free_q;
	logic [SLOT_W-1:0]       found_idx_q, free_idx_q, min_idx_q;
	logic [GEN_W-1:0]        min_gen_q;
	logic                    last_cmp;

	logic [SLOT_W-1:0]       res_slot_q;
	logic                    res_hit_q, res_acc_q;

	logic                    out_valid_q;
	logic                    out_free;

	// scan end helpers
	logic [TABLE_SLOTS-1:0]  sweep_clear;
	logic                    end_unbind;
	assoc_t                  end_state;
	logic                    end_bind;
	logic                    ev_bind_desired;
	logic [GEN_W-1:0]        gen_inc;
	logic                    mem_we;
	logic [SLOT_W-1:0]       wr_idx;

	assign out_free = !out_valid_q || out_ch.ready;
	assign last_cmp = pend_s1 && (idx_s1 == SLOT_W'(TABLE_SLOTS - 1));
	assign gen_inc  = scan_gen_q + GEN_W'(1);

	always_comb begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			sweep_clear[i] = node_valid_q[i] && !node_touched_q[i] &&
				!(bound_q && (bidx_q == SLOT_W'(i)) && (cur_q != ST_INIT));
		end
		end_unbind = bound_q && (cur_q == ST_INIT) && node_valid_q[bidx_q] &&
			!node_touched_q[bidx_q];
		if (cur_q == ST_INIT && op.scanning) begin
			end_state = ST_SCAN;
		end else if (cur_q == ST_SCAN && !op.scanning) begin
			end_state = ST_INIT;
		end else begin
			end_state = cur_q;
		end
		end_bind = !(bound_q && !end_unbind) && (end_state == ST_AUTH ||
			end_state == ST_ASSOC || end_state == ST_RUN) && (desired_q != '0);
		ev_bind_desired = !op.present && !bound_q && (desired_q != '0) &&
			(op.target == ST_AUTH || op.target == ST_ASSOC);
	end

	// outputs of the sequencer
	always_comb begin
		ctl = '0;
		ctl.walk_key = op.bssid;
		if (state_q == B_IDLE && op_valid) begin
			ctl.pop = 1'b1;
			case (op.kind)
				OP_ENTRY: begin
					ctl.start_walk = (total_q != CNT_W'(TABLE_SLOTS));
					ctl.walk_entry = 1'b1;
				end
				OP_END: begin
					ctl.start_walk = end_bind;
					ctl.walk_key   = desired_q;
				end
				OP_DESIRED: ctl.start_walk = op.present;
				OP_EVENT: begin
					if (op.target != ST_INIT && op.present) begin
						ctl.start_walk = 1'b1;
					end else if (op.target != ST_INIT && ev_bind_desired) begin
						ctl.start_walk = 1'b1;
						ctl.walk_key   = desired_q;
					end
				end
				default: ctl.start_walk = 1'b0;
			endcase
		end
	end
	assign op_pop = ctl.pop;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			B_IDLE: begin
				if (op_valid) begin
					state_nxt = ctl.start_walk ? B_WALK : B_EMIT;
				end
			end
			B_WALK:   if (last_cmp) state_nxt = B_FINISH;
			B_FINISH: state_nxt = B_EMIT;
			B_EMIT:   if (out_free) state_nxt = B_IDLE;
			default:  state_nxt = B_IDLE;
		endcase
	end

	assign wr_idx = found_q ? found_idx_q : (free_q ? free_idx_q : min_idx_q);
	assign mem_we = (state_q == B_FINISH) && walk_entry_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_addr_mem[wr_idx] <= key_q;
			node_gen_mem[wr_idx]  <= scan_gen_q;
		end
		rd_addr_s1 <= node_addr_mem[cnt_q[SLOT_W-1:0]];
		rd_gen_s1  <= node_gen_mem[cnt_q[SLOT_W-1:0]];
		idx_s1     <= cnt_q[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			node_valid_q   <= '0;
			node_touched_q <= '0;
			total_q        <= '0;
			scan_gen_q     <= '0;
			cur_q          <= ST_INIT;
			bound_q        <= 1'b0;
			bidx_q         <= '0;
			desired_q      <= '0;
			cnt_q          <= '0;
			walk_entry_q   <= 1'b0;
			key_q          <= '0;
			pend_s1        <= 1'b0;
			found_q        <= 1'b0;
			free_q         <= 1'b0;
			found_idx_q    <= '0;
			free_idx_q     <= '0;
			min_idx_q      <= '0;
			min_gen_q      <= '1;
			res_slot_q     <= '0;
			res_hit_q      <= 1'b0;
			res_acc_q      <= 1'b0;
			out_valid_q    <= 1'b0;
			out_ch.slot          <= '0;
			out_ch.hit           <= 1'b0;
			out_ch.accepted      <= 1'b0;
			out_ch.assoc_state   <= '0;
			out_ch.bound_valid   <= 1'b0;
			out_ch.bound_slot    <= '0;
			out_ch.visible_count <= '0;
		end else begin
			state_q <= state_nxt;
			pend_s1 <= 1'b0;
			if (out_valid_q && out_ch.ready && state_q != B_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (ctl.pop) begin
						res_slot_q   <= '0;
						res_hit_q    <= 1'b0;
						res_acc_q    <= 1'b0;
						cnt_q        <= '0;
						walk_entry_q <= ctl.walk_entry;
						key_q        <= ctl.walk_key;
						found_q      <= 1'b0;
						free_q       <= 1'b0;
						found_idx_q  <= '0;
						free_idx_q   <= '0;
						min_idx_q    <= '0;
						min_gen_q    <= '1;
						case (op.kind)
							OP_START: begin
								scan_gen_q     <= (gen_inc == '0) ? GEN_W'(1) : gen_inc;
								node_touched_q <= '0;
								total_q        <= '0;
							end
							OP_END: begin
								node_valid_q <= node_valid_q & ~sweep_clear;
								cur_q        <= end_state;
								if (end_unbind) begin
									bound_q <= 1'b0;
									bidx_q  <= '0;
								end
							end
							OP_DESIRED: begin
								desired_q <= op.present ? op.bssid : '0;
							end
							OP_EVENT: begin
								cur_q <= op.target;
								if (op.target == ST_INIT) begin
									bound_q <= 1'b0;
									bidx_q  <= '0;
								end
							end
							OP_DISASSOC: begin
								if (cur_q == ST_SCAN || cur_q == ST_RUN) begin
									bound_q   <= 1'b0;
									bidx_q    <= '0;
									desired_q <= '0;
									cur_q     <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				B_WALK: begin
					// issue one read per cycle, compare it the cycle after
					if (cnt_q != CNT_W'(TABLE_SLOTS)) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						pend_s1 <= 1'b1;
					end
					if (pend_s1) begin
						if (node_valid_q[idx_s1] && rd_addr_s1 == key_q && !found_q) begin
							found_q     <= 1'b1;
							found_idx_q <= idx_s1;
						end
						if (!node_valid_q[idx_s1] && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (rd_gen_s1 < min_gen_q) begin
							min_gen_q <= rd_gen_s1;
							min_idx_q <= idx_s1;
						end
					end
				end
				B_FINISH: begin
					if (walk_entry_q) begin
						node_valid_q[wr_idx]   <= 1'b1;
						node_touched_q[wr_idx] <= 1'b1;
						total_q    <= total_q + CNT_W'(1);
						res_slot_q <= wr_idx;
						res_hit_q  <= found_q;
						res_acc_q  <= 1'b1;
					end else begin
						bound_q <= found_q;
						bidx_q  <= found_q ? found_idx_q : '0;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						out_valid_q          <= 1'b1;
						out_ch.slot          <= res_slot_q;
						out_ch.hit           <= res_hit_q;
						out_ch.accepted      <= res_acc_q;
						out_ch.assoc_state   <= cur_q;
						out_ch.bound_valid   <= bound_q;
						out_ch.bound_slot    <= bidx_q;
						out_ch.visible_count <= total_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;

`ifndef SYNTH
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(TABLE_SLOTS))
		else $error("snapshot count past table size");
	a_unbound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!bound_q |-> bidx_q == '0)
		else $error("bound index set while unbound");
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.pop && op.kind == OP_START) |=> (total_q == '0 && scan_gen_q != '0))
		else $error("scan start did not reset snapshot");
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last_cmp |=> state_q == B_FINISH)
		else $error("walk did not finish after last slot");
`endif

endmodule

[src/bssid_node_table_with_assoc_state.sv]
// sequencing: a request that needs no table walk goes from the queue through the emit state
// to the result register; a scan entry into a table that is not full, or a bind, first walks
// all 64 slots through one registered read port of the address and generation memories
// flow: one request at a time in the back end; a 2-entry queue keeps taking requests until it is full
// reset: arst_n clears the valid and touched bits, counters, state and queue at once
`timescale 1ns / 1ps
module bssid_node_table_with_assoc_state
	import bnt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bnt_in_if.sink    in_ch,
	bnt_out_if.source out_ch
);

	// request passed from the front end's queue to the back end
	op_t  op;
	logic op_valid;
	logic op_pop;

	// front end: takes requests, decodes the mode and queues them
	bnt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.op       (op),
		.op_valid (op_valid),
		.op_pop   (op_pop)
	);

	// back end: table walks, sweep, association state and the result register
	bnt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.op_valid (op_valid),
		.op_pop   (op_pop),
		.out_ch   (out_ch)
	);

endmodule
